// ===== design/ilir_pkg.sv =====
// ----------------------------------------------------------------------------
// ilir_pkg
// Shared types and constants for the indexed list with shifting insert/remove.
// ----------------------------------------------------------------------------
`default_nettype none

package ilir_pkg;

  localparam int unsigned ModeW     = 3;
  localparam int unsigned PosW      = 4;
  localparam int unsigned InWordW   = 32;
  localparam int unsigned OutWordW  = 32;
  localparam int unsigned CountOutW = 5;
  localparam int unsigned StatusW   = 2;

  // index/bound width for the cell control, covers the largest list (256)
  localparam int unsigned IdxW = 9;

  typedef enum logic [ModeW-1:0] {
    MODE_APPEND    = 3'd0,
    MODE_POP       = 3'd1,
    MODE_READ      = 3'd2,
    MODE_OVERWRITE = 3'd3,
    MODE_INSERT    = 3'd4,
    MODE_REMOVE    = 3'd5,
    MODE_CLEAR     = 3'd6
  } mode_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  // broadcast to every cell in the chain
  typedef struct packed {
    logic            wr_en;
    logic [IdxW-1:0] wr_idx;
    logic            shift_up;    // cells lo < i <= hi take the lower neighbor
    logic            shift_down;  // cells lo <= i < hi take the upper neighbor
    logic [IdxW-1:0] lo;
    logic [IdxW-1:0] hi;
  } cell_ctl_t;

endpackage

`default_nettype wire

// ===== design/ilir_if.sv =====
// ----------------------------------------------------------------------------
// ilir_if
// Request and response channels of the indexed list (valid/ready).
// ----------------------------------------------------------------------------
`default_nettype none

interface ilir_req_if;
  logic                                valid;
  logic                                ready;
  logic [ilir_pkg::ModeW-1:0]          mode;
  logic [ilir_pkg::PosW-1:0]           position;
  logic [ilir_pkg::InWordW-1:0]        word_in;

  modport source (output valid, output mode, output position, output word_in, input ready);
  modport sink   (input valid, input mode, input position, input word_in, output ready);
endinterface

interface ilir_rsp_if;
  logic                                valid;
  logic                                ready;
  logic [ilir_pkg::OutWordW-1:0]       word_out;
  logic [ilir_pkg::CountOutW-1:0]      count_out;
  logic [ilir_pkg::StatusW-1:0]        status;

  modport source (output valid, output word_out, output count_out, output status, input ready);
  modport sink   (input valid, input word_out, input count_out, input status, output ready);
endinterface

`default_nettype wire

// ===== design/ilir_cell.sv =====
// ----------------------------------------------------------------------------
// ilir_cell
// One list entry: holds its word, loads from a neighbor or the request word.
// ----------------------------------------------------------------------------
`default_nettype none

module ilir_cell #(
  parameter int unsigned IDX       = 0,
  parameter int unsigned WORD_BITS = 32
) (
  input  wire logic                     clk_i,
  input  wire ilir_pkg::cell_ctl_t      ctl_i,
  input  wire logic [WORD_BITS-1:0]     word_i,
  input  wire logic [WORD_BITS-1:0]     left_i,
  input  wire logic [WORD_BITS-1:0]     right_i,
  output logic      [WORD_BITS-1:0]     q_o
);

  localparam logic [ilir_pkg::IdxW-1:0] Me = ilir_pkg::IdxW'(IDX);

  logic [WORD_BITS-1:0] q_q;
  logic [WORD_BITS-1:0] q_d;

  always_comb begin
    q_d = q_q;
    if (ctl_i.shift_up && (Me > ctl_i.lo) && (Me <= ctl_i.hi)) begin
      q_d = left_i;
    end else if (ctl_i.shift_down && (Me >= ctl_i.lo) && (Me < ctl_i.hi)) begin
      q_d = right_i;
    end
    if (ctl_i.wr_en && (Me == ctl_i.wr_idx)) begin
      q_d = word_i;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q <= q_d;
  end

  assign q_o = q_q;

endmodule

`default_nettype wire

// ===== design/indexed_list_insert_remove.sv =====
// The response to a request is registered at the clock edge that transfers it.
// Throughput: one request per cycle unless a held response stalls it; every
//   cell loads from a neighbor or the request word in parallel, so a shift is done at once.
// The response register takes a new result whenever it is empty or being drained.
// Reset clears the entry count and the response valid; entry words are unknown
//   until written and are never read before that.
// ----------------------------------------------------------------------------
// indexed_list_insert_remove
// Fixed-capacity ordered list of words with append, pop, read, overwrite,
// shifting insert and remove, and clear, built as a chain of entry cells.
// ----------------------------------------------------------------------------
`default_nettype none

module indexed_list_insert_remove #(
  parameter int unsigned CAPACITY  = 16,
  parameter int unsigned WORD_BITS = 32
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  ilir_req_if.sink       in_i,
  ilir_rsp_if.source     out_o
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam int unsigned CmpW = (CntW > ilir_pkg::PosW) ? CntW : ilir_pkg::PosW;

  logic                       acc;
  logic [CntW-1:0]            count_q, count_d;
  logic                       out_vld_q;
  logic [ilir_pkg::OutWordW-1:0]  word_out_q, word_out_d;
  logic [ilir_pkg::CountOutW-1:0] count_out_q;
  ilir_pkg::status_e          status_q, status_d;
  ilir_pkg::cell_ctl_t        ctl;

  logic [CmpW-1:0]            pos_ext, cnt_ext, rd_idx;
  logic [63:0]                win_ext, rd_ext;
  logic [WORD_BITS-1:0]       word_store, rd_word;
  logic                       give_word;
  logic [CntW+ilir_pkg::CountOutW-1:0] cnt_wide;

  logic [WORD_BITS-1:0]       cell_q [CAPACITY];

  assign in_i.ready = !out_vld_q || out_o.ready;
  assign acc        = in_i.valid && in_i.ready;

  assign pos_ext    = CmpW'(in_i.position);
  assign cnt_ext    = CmpW'(count_q);
  assign win_ext    = 64'(in_i.word_in);
  assign word_store = win_ext[WORD_BITS-1:0];

  // ---- request decode ----
  always_comb begin
    count_d    = count_q;
    status_d   = ilir_pkg::ST_OK;
    give_word  = 1'b0;
    rd_idx     = pos_ext;
    ctl        = '0;
    unique case (in_i.mode)
      ilir_pkg::MODE_APPEND: begin
        if (count_q == CntW'(CAPACITY)) begin
          status_d = ilir_pkg::ST_FULL;
        end else begin
          ctl.wr_en  = 1'b1;
          ctl.wr_idx = ilir_pkg::IdxW'(count_q);
          count_d    = count_q + CntW'(1);
        end
      end
      ilir_pkg::MODE_POP: begin
        rd_idx = cnt_ext - CmpW'(1);
        if (count_q == '0) begin
          status_d = ilir_pkg::ST_EMPTY;
        end else begin
          give_word = 1'b1;
          count_d   = count_q - CntW'(1);
        end
      end
      ilir_pkg::MODE_READ: begin
        if (count_q == '0) begin
          status_d = ilir_pkg::ST_EMPTY;
        end else if (pos_ext >= cnt_ext) begin
          status_d = ilir_pkg::ST_RANGE;
        end else begin
          give_word = 1'b1;
        end
      end
      ilir_pkg::MODE_OVERWRITE: begin
        if (count_q == '0) begin
          status_d = ilir_pkg::ST_EMPTY;
        end else if (pos_ext >= cnt_ext) begin
          status_d = ilir_pkg::ST_RANGE;
        end else begin
          ctl.wr_en  = 1'b1;
          ctl.wr_idx = ilir_pkg::IdxW'(pos_ext);
        end
      end
      ilir_pkg::MODE_INSERT: begin
        if (count_q == CntW'(CAPACITY)) begin
          status_d = ilir_pkg::ST_FULL;
        end else if (pos_ext > cnt_ext) begin
          status_d = ilir_pkg::ST_RANGE;
        end else begin
          ctl.wr_en    = 1'b1;
          ctl.wr_idx   = ilir_pkg::IdxW'(pos_ext);
          ctl.shift_up = 1'b1;
          ctl.lo       = ilir_pkg::IdxW'(pos_ext);
          ctl.hi       = ilir_pkg::IdxW'(cnt_ext);
          count_d      = count_q + CntW'(1);
        end
      end
      ilir_pkg::MODE_REMOVE: begin
        if (count_q == '0) begin
          status_d = ilir_pkg::ST_EMPTY;
        end else if (pos_ext >= cnt_ext) begin
          status_d = ilir_pkg::ST_RANGE;
        end else begin
          give_word      = 1'b1;
          ctl.shift_down = 1'b1;
          ctl.lo         = ilir_pkg::IdxW'(pos_ext);
          ctl.hi         = ilir_pkg::IdxW'(cnt_ext - CmpW'(1));
          count_d        = count_q - CntW'(1);
        end
      end
      ilir_pkg::MODE_CLEAR: begin
        count_d = '0;
      end
      default: begin
        // unused code: no change
      end
    endcase
    if (!acc) begin
      ctl = '0;
    end
  end

  // ---- cell chain ----
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [WORD_BITS-1:0] left_w, right_w;
    if (g == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = cell_q[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = cell_q[g+1];
    end
    ilir_cell #(
      .IDX       (g),
      .WORD_BITS (WORD_BITS)
    ) u_cell (
      .clk_i   (clk_i),
      .ctl_i   (ctl),
      .word_i  (word_store),
      .left_i  (left_w),
      .right_i (right_w),
      .q_o     (cell_q[g])
    );
  end

  // read select over the chain
  always_comb begin
    rd_word = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (rd_idx == CmpW'(i)) begin
        rd_word = cell_q[i];
      end
    end
  end

  assign rd_ext     = 64'(rd_word);
  assign word_out_d = give_word ? rd_ext[ilir_pkg::OutWordW-1:0] : '0;
  assign cnt_wide   = (CntW + ilir_pkg::CountOutW)'(count_d);

  // ---- state and response register ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (acc) begin
        count_q   <= count_d;
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      word_out_q  <= word_out_d;
      count_out_q <= cnt_wide[ilir_pkg::CountOutW-1:0];
      status_q    <= status_d;
    end
  end

  assign out_o.valid     = out_vld_q;
  assign out_o.word_out  = word_out_q;
  assign out_o.count_out = count_out_q;
  assign out_o.status    = status_q;

  // ---- assertions ----
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(CAPACITY))
    else $error("entry count above capacity");

  a_refused_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && (status_d != ilir_pkg::ST_OK) |=> count_q == $past(count_q))
    else $error("refused request changed the count");

  a_rsp_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |=> out_vld_q && (out_o.count_out == $past(cnt_wide[ilir_pkg::CountOutW-1:0])))
    else $error("response missing after request transfer");

  a_word_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && !give_word |=> word_out_q == '0)
    else $error("nonzero word on a request that returns none");

endmodule

`default_nettype wire

// ===== tb/indexed_list_insert_remove_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// indexed_list_insert_remove_tb
// Self-checking bench for the indexed list. A directed pass hits the empty
// and out-of-range refusals and insert at the end of the list. A random
// pass then alternates growing and draining the list with random words and
// positions. Both handshakes get random gaps, and one long response stall
// backs the block up. Every response is checked against a scoreboard that
// tracks the list contents and the count.
// ----------------------------------------------------------------------------

localparam int unsigned ListDepth  = 16;
localparam logic [2:0]  ModeUnused = 3'd7;

typedef struct {
  logic [31:0]        word;
  logic [4:0]         count;
  ilir_pkg::status_e  status;
} reply_t;

class list_scoreboard;
  logic [31:0] slots [ListDepth];
  int unsigned fill;
  reply_t      expected_replies [$];
  int unsigned errors;
  int unsigned accepted;
  int unsigned checked;
  int unsigned status_seen [4];
  int unsigned full_hits;
  int unsigned empty_hits;

  function new();
    fill       = 0;
    errors     = 0;
    accepted   = 0;
    checked    = 0;
    full_hits  = 0;
    empty_hits = 0;
    foreach (status_seen[i]) status_seen[i] = 0;
  endfunction

  // update the list for one accepted request and queue the reply it owes
  function void note_request(logic [2:0] m, logic [3:0] p, logic [31:0] w);
    reply_t r;
    int unsigned i;
    r.word   = '0;
    r.status = ilir_pkg::ST_OK;
    accepted++;
    case (m)
      ilir_pkg::MODE_APPEND: begin
        if (fill >= ListDepth) begin
          r.status = ilir_pkg::ST_FULL;
        end else begin
          slots[fill] = w;
          fill++;
          if (fill == ListDepth) full_hits++;
        end
      end
      ilir_pkg::MODE_POP: begin
        if (fill == 0) begin
          r.status = ilir_pkg::ST_EMPTY;
        end else begin
          fill--;
          r.word = slots[fill];
          if (fill == 0) empty_hits++;
        end
      end
      ilir_pkg::MODE_READ: begin
        if (fill == 0) r.status = ilir_pkg::ST_EMPTY;
        else if (p >= fill) r.status = ilir_pkg::ST_RANGE;
        else r.word = slots[p];
      end
      ilir_pkg::MODE_OVERWRITE: begin
        if (fill == 0) r.status = ilir_pkg::ST_EMPTY;
        else if (p >= fill) r.status = ilir_pkg::ST_RANGE;
        else slots[p] = w;
      end
      ilir_pkg::MODE_INSERT: begin
        if (fill >= ListDepth) begin
          r.status = ilir_pkg::ST_FULL;
        end else if (p > fill) begin
          r.status = ilir_pkg::ST_RANGE;
        end else begin
          for (i = fill; i > p; i--) slots[i] = slots[i-1];
          slots[p] = w;
          fill++;
          if (fill == ListDepth) full_hits++;
        end
      end
      ilir_pkg::MODE_REMOVE: begin
        if (fill == 0) begin
          r.status = ilir_pkg::ST_EMPTY;
        end else if (p >= fill) begin
          r.status = ilir_pkg::ST_RANGE;
        end else begin
          r.word = slots[p];
          for (i = p; i + 1 < fill; i++) slots[i] = slots[i+1];
          fill--;
          if (fill == 0) empty_hits++;
        end
      end
      ilir_pkg::MODE_CLEAR: fill = 0;
      default: ;  // unused code: no change
    endcase
    r.count = 5'(fill);
    expected_replies.push_back(r);
  endfunction

  function void check_response(logic [31:0] w, logic [4:0] c, logic [1:0] s);
    reply_t e;
    if (expected_replies.size() == 0) begin
      $display("%0t: unexpected response: word %h count %0d status %0d", $time, w, c, s);
      errors++;
      return;
    end
    e = expected_replies.pop_front();
    checked++;
    status_seen[e.status]++;
    if (w !== e.word) begin
      $display("%0t: word_out mismatch: expected %h, got %h", $time, e.word, w);
      errors++;
    end
    if (c !== e.count) begin
      $display("%0t: count_out mismatch: expected %0d, got %0d", $time, e.count, c);
      errors++;
    end
    if (s !== e.status) begin
      $display("%0t: status mismatch: expected %0d, got %0d", $time, e.status, s);
      errors++;
    end
  endfunction
endclass

module indexed_list_insert_remove_tb;

  localparam int unsigned NumRandom  = 1700;
  localparam int unsigned CycleLimit = 1000000;
  localparam int unsigned HoldCycles = 300;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic hold_rsp;
  bit   grow = 1'b1;
  int unsigned cycles = 0;

  list_scoreboard sb = new();

  ilir_req_if req_if ();
  ilir_rsp_if rsp_if ();

  indexed_list_insert_remove #(
    .CAPACITY  (ListDepth),
    .WORD_BITS (32)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_if),
    .out_o  (rsp_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("%0t: timeout with %0d replies outstanding", $time,
               sb.expected_replies.size());
      $display("indexed_list_insert_remove_tb: errors");
      $finish;
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_request(input logic [2:0] m, input logic [3:0] p,
                              input logic [31:0] w, input bit gaps_on);
    int unsigned gap;
    gap = gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid    <= 1'b1;
    req_if.mode     <= m;
    req_if.position <= p;
    req_if.word_in  <= w;
    do @(posedge clk_i); while (!req_if.ready);
    sb.note_request(m, p, w);
  endtask

  function automatic logic [3:0] pick_position(logic [2:0] m);
    int unsigned bound;
    if (sb.fill == 0 || $urandom_range(0, 4) == 0) return 4'($urandom_range(0, 15));
    bound = (m == ilir_pkg::MODE_INSERT) ? sb.fill : sb.fill - 1;
    if (bound > 15) bound = 15;
    return 4'($urandom_range(0, bound));
  endfunction

  function automatic logic [31:0] pick_word();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return $urandom;
  endfunction

  // grow phases lean on append/insert, drain phases on remove/pop
  function automatic logic [2:0] pick_mode();
    int unsigned r;
    if (grow && sb.fill == ListDepth && $urandom_range(0, 3) == 0) grow = 1'b0;
    else if (!grow && sb.fill == 0 && $urandom_range(0, 3) == 0) grow = 1'b1;
    r = $urandom_range(0, 99);
    if (r < 1) return ModeUnused;
    if (r < 2) return ilir_pkg::MODE_CLEAR;
    if (grow) begin
      if (r < 30) return ilir_pkg::MODE_APPEND;
      if (r < 58) return ilir_pkg::MODE_INSERT;
      if (r < 70) return ilir_pkg::MODE_READ;
      if (r < 82) return ilir_pkg::MODE_OVERWRITE;
      if (r < 91) return ilir_pkg::MODE_REMOVE;
      return ilir_pkg::MODE_POP;
    end
    if (r < 10) return ilir_pkg::MODE_APPEND;
    if (r < 20) return ilir_pkg::MODE_INSERT;
    if (r < 35) return ilir_pkg::MODE_READ;
    if (r < 47) return ilir_pkg::MODE_OVERWRITE;
    if (r < 75) return ilir_pkg::MODE_REMOVE;
    return ilir_pkg::MODE_POP;
  endfunction

  // response side
  initial begin
    int unsigned stall_left;
    bit stalls_on;
    int unsigned epoch_left;
    stall_left = 0;
    stalls_on  = 1'b1;
    epoch_left = $urandom_range(100, 300);
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rsp_if.valid && rsp_if.ready)
        sb.check_response(rsp_if.word_out, rsp_if.count_out, rsp_if.status);
      if (epoch_left == 0) begin
        stalls_on  = !stalls_on;
        epoch_left = $urandom_range(100, 300);
      end else begin
        epoch_left--;
      end
      if (hold_rsp) begin
        rsp_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        rsp_if.ready <= 1'b0;
      end else if (stalls_on && $urandom_range(0, 3) == 0) begin
        stall_left = pick_gap();
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  // one long hold on the response side, so the block backs up and stalls requests
  initial begin
    hold_rsp <= 1'b0;
    while (sb.accepted < 400) @(posedge clk_i);
    hold_rsp <= 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    hold_rsp <= 1'b0;
  end

  initial begin
    int unsigned n;
    logic [2:0] m;
    rst_ni          <= 1'b0;
    req_if.valid    <= 1'b0;
    req_if.mode     <= ilir_pkg::MODE_APPEND;
    req_if.position <= '0;
    req_if.word_in  <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // refusals on an empty list
    send_request(ilir_pkg::MODE_POP,       4'd0,  32'h0000_0000, 1'b1);
    send_request(ilir_pkg::MODE_READ,      4'd0,  32'h0000_0000, 1'b1);
    send_request(ilir_pkg::MODE_OVERWRITE, 4'd0,  32'hFFFF_FFFF, 1'b1);
    send_request(ilir_pkg::MODE_REMOVE,    4'd15, 32'h0000_0000, 1'b1);
    send_request(ilir_pkg::MODE_INSERT,    4'd1,  32'hFFFF_FFFF, 1'b1);
    // insert at count acts as append
    send_request(ilir_pkg::MODE_INSERT,    4'd0,  32'hFFFF_FFFF, 1'b1);
    send_request(ilir_pkg::MODE_APPEND,    4'd15, 32'h0000_0000, 1'b1);
    send_request(ilir_pkg::MODE_INSERT,    4'd2,  32'hAAAA_AAAA, 1'b1);
    send_request(ilir_pkg::MODE_INSERT,    4'd1,  32'h5555_5555, 1'b1);
    send_request(ilir_pkg::MODE_READ,      4'd1,  32'h0000_0000, 1'b1);
    send_request(ilir_pkg::MODE_READ,      4'd4,  32'h0000_0000, 1'b1);
    send_request(ilir_pkg::MODE_OVERWRITE, 4'd15, 32'h1234_5678, 1'b1);
    send_request(ilir_pkg::MODE_OVERWRITE, 4'd3,  32'h8000_0001, 1'b1);
    send_request(ilir_pkg::MODE_REMOVE,    4'd4,  32'h0000_0000, 1'b1);
    send_request(ilir_pkg::MODE_REMOVE,    4'd0,  32'h0000_0000, 1'b1);
    send_request(ModeUnused,               4'd15, 32'hFFFF_FFFF, 1'b1);
    send_request(ilir_pkg::MODE_POP,       4'd0,  32'h0000_0000, 1'b1);
    send_request(ilir_pkg::MODE_CLEAR,     4'd0,  32'h0000_0000, 1'b1);
    send_request(ilir_pkg::MODE_READ,      4'd0,  32'h0000_0000, 1'b1);

    for (n = 0; n < NumRandom; n++) begin
      m = pick_mode();
      send_request(m, pick_position(m), pick_word(), ((n / 150) % 3) != 2);
    end
    req_if.valid <= 1'b0;

    while (sb.expected_replies.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);

    $display("%0d requests, %0d replies checked (ok %0d, full %0d, empty %0d, range %0d)",
             sb.accepted, sb.checked, sb.status_seen[ilir_pkg::ST_OK],
             sb.status_seen[ilir_pkg::ST_FULL], sb.status_seen[ilir_pkg::ST_EMPTY],
             sb.status_seen[ilir_pkg::ST_RANGE]);
    $display("list filled to capacity %0d times, drained to empty %0d times",
             sb.full_hits, sb.empty_hits);
    if (sb.errors == 0) begin
      $display("indexed_list_insert_remove_tb: clean");
    end else begin
      $display("indexed_list_insert_remove_tb: errors");
    end
    $finish;
  end

endmodule
